// ===== hdl/gbe_pkg.sv =====
`timescale 1ns / 1ps

package gbe_pkg;

  localparam int POS_W = 40;
  localparam int FRAC = 16;
  localparam int VEL_W = 32;
  localparam int DLT_W = POS_W + 1;
  localparam int DT_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [63:0] ONE = 64'd1 << FRAC;
  localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC);
  localparam logic [63:0] EARTH_GM = 64'd398589196000000;
  // speed*1000 >= one and dist*10 >= one as plain thresholds
  localparam logic [63:0] DRAG_MIN = (ONE + 64'd999) / 64'd1000;
  localparam logic [63:0] THR_MIN = (ONE + 64'd9) / 64'd10;
  localparam logic [63:0] TMAG_DIV = 64'd167772160;
  localparam logic [63:0] DRAG_DIV = 64'd1 << 33;
  localparam logic [63:0] DT_DIV = 64'd65536;
  localparam logic [63:0] MASS_SCALE = 64'd256;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, {63{1'b0}}};
  localparam logic signed [63:0] VEL_MAX = (64'sd1 <<< (VEL_W - 1)) - 64'sd1;
  localparam logic signed [63:0] VEL_MIN = -VEL_MAX - 64'sd1;
  localparam logic signed [63:0] POS_MAX = (64'sd1 <<< (POS_W - 1)) - 64'sd1;
  localparam logic signed [63:0] POS_MIN = -POS_MAX - 64'sd1;

  localparam logic [3:0] K_BRAKE = 4'd8;
  localparam logic [3:0] K_COAST = 4'd5;
  localparam logic [3:0] K_FULL = 4'd10;

  localparam logic [15:0] RST_BODY_MASS = 16'd12800;
  localparam logic [19:0] RST_THRUST_LIMIT = 20'd25600;
  localparam logic [15:0] RST_DRAG_COEFF = 16'd6554;
  localparam logic [23:0] RST_FRONTAL_AREA = 24'd32768;
  localparam logic [30:0] RST_SPEED_LIMIT = 31'd3276800;
  localparam logic [30:0] RST_ACCEL_LIMIT = 31'd655360;
  localparam logic [16:0] RST_PRECISION_GAIN = 17'd62259;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BODY_MASS      = 3'd0,
    REG_THRUST_LIMIT   = 3'd1,
    REG_DRAG_COEFF     = 3'd2,
    REG_FRONTAL_AREA   = 3'd3,
    REG_SPEED_LIMIT    = 3'd4,
    REG_ACCEL_LIMIT    = 3'd5,
    REG_PRECISION_GAIN = 3'd6,
    REG_IN_VACUUM      = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MD_IDLE,
    MD_MUL,
    MD_CHK,
    MD_DIV,
    MD_FIN
  } md_state_t;

  typedef enum logic [2:0] {
    MG_IDLE,
    MG_NORM,
    MG_SQ,
    MG_ROOT,
    MG_SHL
  } mg_state_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_G_MAG,
    ST_G_DIV1,
    ST_G_DIV2,
    ST_G_MASS,
    ST_G_FRC,
    ST_D_MAG,
    ST_D_AREA,
    ST_D_V2,
    ST_D_DMAG,
    ST_D_FRC,
    ST_T_MAG,
    ST_T_SAFE,
    ST_T_K,
    ST_T_PG,
    ST_T_MAG2,
    ST_T_FRC,
    ST_A_DIV,
    ST_A_MAG,
    ST_A_SCL,
    ST_A_SAT,
    ST_V_INT,
    ST_V_MAG,
    ST_V_SCL,
    ST_P_INT,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic start;
    logic sgn;
  } md_ctl_t;

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_neg64(input logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = (x > VEL_MAX) ? VEL_MAX : ((x < VEL_MIN) ? VEL_MIN : x);
    return y[VEL_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [63:0] x);
    logic signed [63:0] y;
    y = (x > POS_MAX) ? POS_MAX : ((x < POS_MIN) ? POS_MIN : x);
    return y[POS_W-1:0];
  endfunction

endpackage

// ===== hdl/gbe_muldiv.sv =====
`timescale 1ns / 1ps

module gbe_muldiv (
  input  logic            clk,
  input  logic            rst,
  input  gbe_pkg::md_ctl_t ctl,
  input  logic [63:0]     a,
  input  logic [63:0]     b,
  input  logic [63:0]     c,
  output logic            done,
  output logic [63:0]     res
);
  import gbe_pkg::*;

  md_state_t state, state_next;
  logic        sgn;
  logic        neg;
  logic [63:0] am;
  logic [63:0] bm;
  logic [63:0] cm;
  logic [127:0] prod;
  logic [1:0]  k;
  logic [5:0]  cnt;

  logic [31:0]  a_part;
  logic [31:0]  b_part;
  logic [63:0]  pp;
  logic [127:0] addend;
  logic [64:0]  trial;
  logic [64:0]  diff;
  logic         ge;
  logic [63:0]  q;

  // 32x32 partial products, one per cycle
  always_comb begin
    a_part = k[1] ? am[63:32] : am[31:0];
    b_part = k[0] ? bm[63:32] : bm[31:0];
    pp = a_part * b_part;
    case (k)
      2'd0: addend = {64'd0, pp};
      2'd3: addend = {pp, 64'd0};
      default: addend = {32'd0, pp, 32'd0};
    endcase
  end

  // restoring divide, quotient shifts into the low half
  always_comb begin
    trial = {prod[127:64], prod[63]};
    ge = trial >= {1'b0, cm};
    diff = trial - {1'b0, cm};
    q = prod[63:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      MD_IDLE: if (ctl.start) state_next = MD_MUL;
      MD_MUL:  if (k == 2'd3) state_next = MD_CHK;
      MD_CHK:  state_next = (prod[127:64] >= cm) ? MD_FIN : MD_DIV;
      MD_DIV:  if (cnt == 6'd63) state_next = MD_FIN;
      MD_FIN:  state_next = MD_IDLE;
      default: state_next = MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MD_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == MD_FIN);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MD_IDLE: begin
        if (ctl.start) begin
          sgn <= ctl.sgn;
          neg <= ctl.sgn & a[63];
          am <= (ctl.sgn && a[63]) ? 64'd0 - a : a;
          bm <= b;
          cm <= c;
          prod <= '0;
          k <= 2'd0;
        end
      end
      MD_MUL: begin
        prod <= prod + addend;
        k <= k + 2'd1;
      end
      MD_CHK: begin
        cnt <= 6'd0;
        // quotient would not fit: saturate
        if (prod[127:64] >= cm) prod[63:0] <= '1;
      end
      MD_DIV: begin
        prod <= {(ge ? diff[63:0] : trial[63:0]), prod[62:0], ge};
        cnt <= cnt + 6'd1;
      end
      MD_FIN: begin
        if (!sgn) res <= q;
        else if (!neg) res <= q[63] ? S64_MAX : q;
        else res <= q[63] ? S64_MIN : 64'd0 - q;
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/gbe_mag3.sv =====
`timescale 1ns / 1ps

module gbe_mag3 (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] v0,
  input  logic [63:0] v1,
  input  logic [63:0] v2,
  output logic        done,
  output logic [63:0] res
);
  import gbe_pkg::*;

  mg_state_t state, state_next;
  logic [63:0] mv [3];
  logic [5:0]  sh;
  logic [1:0]  cnt;
  logic [63:0] n;
  logic [63:0] bitv;
  logic [63:0] root;
  logic [61:0] sq;
  logic [63:0] rb;
  logic        big;

  always_comb begin
    big = |((mv[0] | mv[1] | mv[2]) >> 31);
    sq = mv[0][30:0] * mv[0][30:0];
    rb = root + bitv;
  end

  assign res = root;

  always_comb begin
    state_next = state;
    unique case (state)
      MG_IDLE: if (start) state_next = MG_NORM;
      MG_NORM: if (!big) state_next = MG_SQ;
      MG_SQ:   if (cnt == 2'd2) state_next = MG_ROOT;
      MG_ROOT: if (bitv == 64'd1) state_next = MG_SHL;
      MG_SHL:  if (sh == 6'd0) state_next = MG_IDLE;
      default: state_next = MG_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= MG_IDLE;
      done <= 1'b0;
    end else begin
      state <= state_next;
      done <= (state == MG_SHL) && (sh == 6'd0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      MG_IDLE: begin
        if (start) begin
          mv[0] <= v0[63] ? 64'd0 - v0 : v0;
          mv[1] <= v1[63] ? 64'd0 - v1 : v1;
          mv[2] <= v2[63] ? 64'd0 - v2 : v2;
          sh <= 6'd0;
        end
      end
      MG_NORM: begin
        cnt <= 2'd0;
        n <= '0;
        if (big) begin
          mv[0] <= mv[0] >> 1;
          mv[1] <= mv[1] >> 1;
          mv[2] <= mv[2] >> 1;
          sh <= sh + 6'd1;
        end
      end
      MG_SQ: begin
        n <= n + {2'b00, sq};
        mv[0] <= mv[1];
        mv[1] <= mv[2];
        cnt <= cnt + 2'd1;
        root <= '0;
        bitv <= 64'd1 << 62;
      end
      MG_ROOT: begin
        if (n >= rb) begin
          n <= n - rb;
          root <= (root >> 1) + bitv;
        end else begin
          root <= root >> 1;
        end
        bitv <= bitv >> 2;
      end
      MG_SHL: begin
        if (sh != 6'd0) begin
          root <= root << 1;
          sh <= sh - 6'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== hdl/guided_body_euler_step_top.sv =====
`timescale 1ns / 1ps

// Guided point body: each transfer on the input channel carries a target point and a time
// step and yields one result with the new position, velocity and clamped acceleration after
// one Euler step with thrust, drag and Earth gravity. Multiplies, divides and magnitudes run
// through a single multiply-divide unit (32x32 partial products, then restoring divide) and
// a magnitude unit (normalize, sum of squares, 32-step square root). An item takes between
// 9 and 34 multiply-divide operations and 4 or 5 magnitudes depending on which forces are
// active; input is not ready until the item finishes and its result is in the output
// register. A finished result sits in that output register, so the next item may start while
// it waits to be taken.
module guided_body_euler_step_top (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [gbe_pkg::POS_W-1:0] target_x,
  input  logic signed [gbe_pkg::POS_W-1:0] target_y,
  input  logic signed [gbe_pkg::POS_W-1:0] target_z,
  input  logic [gbe_pkg::DT_W-1:0] step_time,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [gbe_pkg::POS_W-1:0] pos_x,
  output logic signed [gbe_pkg::POS_W-1:0] pos_y,
  output logic signed [gbe_pkg::POS_W-1:0] pos_z,
  output logic signed [gbe_pkg::VEL_W-1:0] vel_x,
  output logic signed [gbe_pkg::VEL_W-1:0] vel_y,
  output logic signed [gbe_pkg::VEL_W-1:0] vel_z,
  output logic signed [gbe_pkg::VEL_W-1:0] acc_x,
  output logic signed [gbe_pkg::VEL_W-1:0] acc_y,
  output logic signed [gbe_pkg::VEL_W-1:0] acc_z,
  input  logic cfg_we,
  input  logic [gbe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gbe_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbe_pkg::*;

  localparam logic [1:0] LAST_IDX = 2'd2;

  seq_state_t state, state_next;

  logic [15:0] body_mass;
  logic [19:0] thrust_limit;
  logic [15:0] drag_coeff;
  logic [23:0] frontal_area;
  logic [30:0] speed_limit;
  logic [30:0] accel_limit;
  logic [16:0] precision_gain;
  logic        in_vacuum;

  logic signed [POS_W-1:0] pos [3];
  logic signed [VEL_W-1:0] vel [3];
  logic signed [63:0]      frc [3];
  logic signed [63:0]      acc [3];
  logic signed [DLT_W-1:0] dlt [3];
  logic [DT_W-1:0]         dt;
  logic [63:0] tmp;
  logic [63:0] dcfa;
  logic [63:0] dq;
  logic [63:0] vq;
  logic [63:0] tgt_len;
  logic [63:0] lmag;
  logic [3:0]  kval;
  logic [1:0]  idx;
  logic        launched;

  logic signed [POS_W-1:0] res_pos [3];
  logic signed [VEL_W-1:0] res_vel [3];
  logic signed [VEL_W-1:0] res_acc [3];

  md_ctl_t     md_ctl;
  logic [63:0] md_a;
  logic [63:0] md_b;
  logic [63:0] md_c;
  logic        md_done;
  logic [63:0] md_res;
  logic        mg_start;
  logic [63:0] mg_v [3];
  logic        mg_done;
  logic [63:0] mg_res;

  logic [63:0] mass;
  logic [63:0] alim;
  logic [63:0] tmax;
  logic [63:0] safety2;
  logic        loop_st;
  logic        md_st;
  logic        mg_st;
  logic        out_load;
  logic signed [63:0] pos_ext;
  logic signed [63:0] vel_ext;
  logic signed [63:0] dlt_ext;

  gbe_muldiv u_muldiv (
    .clk  (clk),
    .rst  (rst),
    .ctl  (md_ctl),
    .a    (md_a),
    .b    (md_b),
    .c    (md_c),
    .done (md_done),
    .res  (md_res)
  );

  gbe_mag3 u_mag3 (
    .clk   (clk),
    .rst   (rst),
    .start (mg_start),
    .v0    (mg_v[0]),
    .v1    (mg_v[1]),
    .v2    (mg_v[2]),
    .done  (mg_done),
    .res   (mg_res)
  );

  always_comb begin
    mass = (body_mass == 16'd0) ? 64'd1 : {48'd0, body_mass};
    alim = (accel_limit == 31'd0) ? 64'd1 : {33'd0, accel_limit};
    tmax = {44'd0, thrust_limit} << (FRAC - 8);
    safety2 = md_res[63] ? '1 : (md_res << 1);
    pos_ext = {{(64 - POS_W){pos[idx][POS_W-1]}}, pos[idx]};
    vel_ext = {{(64 - VEL_W){vel[idx][VEL_W-1]}}, vel[idx]};
    dlt_ext = {{(64 - DLT_W){dlt[idx][DLT_W-1]}}, dlt[idx]};
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  always_comb begin
    loop_st = 1'b0;
    md_st = 1'b0;
    mg_st = 1'b0;
    unique case (state) inside
      ST_G_FRC, ST_D_FRC, ST_T_FRC, ST_A_DIV, ST_A_SCL, ST_V_INT, ST_V_SCL, ST_P_INT: begin
        loop_st = 1'b1;
        md_st = 1'b1;
      end
      ST_G_DIV1, ST_G_DIV2, ST_G_MASS, ST_D_AREA, ST_D_V2, ST_D_DMAG, ST_T_SAFE, ST_T_K,
      ST_T_PG, ST_T_MAG2: md_st = 1'b1;
      ST_G_MAG, ST_D_MAG, ST_T_MAG, ST_A_MAG, ST_V_MAG: mg_st = 1'b1;
      default: ;
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (in_valid) state_next = in_vacuum ? ST_D_MAG : ST_G_MAG;
      ST_G_MAG:  if (mg_done) state_next = ST_G_DIV1;
      ST_G_DIV1: if (md_done) state_next = ST_G_DIV2;
      ST_G_DIV2: if (md_done) state_next = ST_G_MASS;
      ST_G_MASS: if (md_done) state_next = ST_G_FRC;
      ST_G_FRC:  if (md_done && idx == LAST_IDX) state_next = ST_D_MAG;
      ST_D_MAG:  if (mg_done) state_next = (mg_res >= DRAG_MIN) ? ST_D_AREA : ST_T_MAG;
      ST_D_AREA: if (md_done) state_next = ST_D_V2;
      ST_D_V2:   if (md_done) state_next = ST_D_DMAG;
      ST_D_DMAG: if (md_done) state_next = ST_D_FRC;
      ST_D_FRC:  if (md_done && idx == LAST_IDX) state_next = ST_T_MAG;
      ST_T_MAG:  if (mg_done) state_next = (mg_res < THR_MIN) ? ST_A_DIV : ST_T_SAFE;
      ST_T_SAFE: if (md_done) state_next = ST_T_K;
      ST_T_K:    if (md_done) state_next = ST_T_PG;
      ST_T_PG:   if (md_done) state_next = ST_T_MAG2;
      ST_T_MAG2: if (md_done) state_next = ST_T_FRC;
      ST_T_FRC:  if (md_done && idx == LAST_IDX) state_next = ST_A_DIV;
      ST_A_DIV:  if (md_done && idx == LAST_IDX) state_next = ST_A_MAG;
      ST_A_MAG:  if (mg_done) state_next = (mg_res > alim) ? ST_A_SCL : ST_A_SAT;
      ST_A_SCL:  if (md_done && idx == LAST_IDX) state_next = ST_A_SAT;
      ST_A_SAT:  state_next = ST_V_INT;
      ST_V_INT:  if (md_done && idx == LAST_IDX) state_next = ST_V_MAG;
      ST_V_MAG:  if (mg_done) state_next = (mg_res > {33'd0, speed_limit}) ? ST_V_SCL : ST_P_INT;
      ST_V_SCL:  if (md_done && idx == LAST_IDX) state_next = ST_P_INT;
      ST_P_INT:  if (md_done && idx == LAST_IDX) state_next = ST_DONE;
      ST_DONE:   if (out_load) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    in_ready = (state == ST_IDLE);
    md_ctl.start = md_st && !launched;
    md_ctl.sgn = loop_st;
    mg_start = mg_st && !launched;
    md_a = '0;
    md_b = '0;
    md_c = '0;
    mg_v[0] = '0;
    mg_v[1] = '0;
    mg_v[2] = '0;
    unique case (state)
      ST_G_MAG: begin
        mg_v[0] = {{(64 - POS_W){pos[0][POS_W-1]}}, pos[0]};
        mg_v[1] = {{(64 - POS_W){pos[1][POS_W-1]}}, pos[1]};
        mg_v[2] = {{(64 - POS_W){pos[2][POS_W-1]}}, pos[2]};
      end
      ST_D_MAG, ST_V_MAG: begin
        mg_v[0] = {{(64 - VEL_W){vel[0][VEL_W-1]}}, vel[0]};
        mg_v[1] = {{(64 - VEL_W){vel[1][VEL_W-1]}}, vel[1]};
        mg_v[2] = {{(64 - VEL_W){vel[2][VEL_W-1]}}, vel[2]};
      end
      ST_T_MAG: begin
        mg_v[0] = {{(64 - DLT_W){dlt[0][DLT_W-1]}}, dlt[0]};
        mg_v[1] = {{(64 - DLT_W){dlt[1][DLT_W-1]}}, dlt[1]};
        mg_v[2] = {{(64 - DLT_W){dlt[2][DLT_W-1]}}, dlt[2]};
      end
      ST_A_MAG: begin
        mg_v[0] = acc[0];
        mg_v[1] = acc[1];
        mg_v[2] = acc[2];
      end
      ST_G_DIV1: begin md_a = EARTH_GM; md_b = ONE;    md_c = dq; end
      ST_G_DIV2: begin md_a = tmp;      md_b = ONE_SQ; md_c = dq; end
      ST_G_MASS: begin md_a = tmp;      md_b = mass;   md_c = MASS_SCALE; end
      ST_G_FRC:  begin md_a = pos_ext;  md_b = tmp;    md_c = dq; end
      ST_D_AREA: begin
        md_a = {48'd0, drag_coeff};
        md_b = {40'd0, frontal_area};
        md_c = 64'd1;
      end
      ST_D_V2:   begin md_a = vq;      md_b = vq;   md_c = ONE; end
      ST_D_DMAG: begin md_a = tmp;     md_b = dcfa; md_c = DRAG_DIV; end
      ST_D_FRC:  begin md_a = vel_ext; md_b = tmp;  md_c = vq; end
      ST_T_SAFE: begin md_a = vq + (vq << 1); md_b = vq; md_c = alim + (alim << 2); end
      ST_T_K:    begin md_a = {44'd0, thrust_limit}; md_b = {60'd0, kval}; md_c = 64'd1; end
      ST_T_PG:   begin md_a = tmp;     md_b = {47'd0, precision_gain}; md_c = 64'd1; end
      ST_T_MAG2: begin md_a = tmp;     md_b = ONE;  md_c = TMAG_DIV; end
      ST_T_FRC:  begin md_a = dlt_ext; md_b = tmp;  md_c = tgt_len; end
      ST_A_DIV:  begin md_a = frc[idx]; md_b = MASS_SCALE; md_c = mass; end
      ST_A_SCL:  begin md_a = acc[idx]; md_b = alim; md_c = lmag; end
      ST_V_INT:  begin md_a = acc[idx]; md_b = {48'd0, dt}; md_c = DT_DIV; end
      ST_V_SCL:  begin md_a = vel_ext;  md_b = {33'd0, speed_limit}; md_c = lmag; end
      ST_P_INT:  begin md_a = vel_ext;  md_b = {48'd0, dt}; md_c = DT_DIV; end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      launched <= 1'b0;
      idx <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (md_done || mg_done) launched <= 1'b0;
      else if (md_ctl.start || mg_start) launched <= 1'b1;
      if (loop_st && md_done) idx <= (idx == LAST_IDX) ? 2'd0 : idx + 2'd1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      body_mass <= RST_BODY_MASS;
      thrust_limit <= RST_THRUST_LIMIT;
      drag_coeff <= RST_DRAG_COEFF;
      frontal_area <= RST_FRONTAL_AREA;
      speed_limit <= RST_SPEED_LIMIT;
      accel_limit <= RST_ACCEL_LIMIT;
      precision_gain <= RST_PRECISION_GAIN;
      in_vacuum <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BODY_MASS:      body_mass <= cfg_data[15:0];
        REG_THRUST_LIMIT:   thrust_limit <= cfg_data[19:0];
        REG_DRAG_COEFF:     drag_coeff <= cfg_data[15:0];
        REG_FRONTAL_AREA:   frontal_area <= cfg_data[23:0];
        REG_SPEED_LIMIT:    speed_limit <= cfg_data[30:0];
        REG_ACCEL_LIMIT:    accel_limit <= cfg_data[30:0];
        REG_PRECISION_GAIN: precision_gain <= cfg_data[16:0];
        REG_IN_VACUUM:      in_vacuum <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // body state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        pos[i] <= '0;
        vel[i] <= '0;
      end
    end else begin
      if (state == ST_V_INT && md_done)
        vel[idx] <= sat_vel(vel_ext + $signed(md_res));
      if (state == ST_V_SCL && md_done)
        vel[idx] <= md_res[VEL_W-1:0];
      if (state == ST_P_INT && md_done)
        pos[idx] <= sat_pos(pos_ext + $signed(md_res));
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      dlt[0] <= DLT_W'(target_x) - DLT_W'(pos[0]);
      dlt[1] <= DLT_W'(target_y) - DLT_W'(pos[1]);
      dlt[2] <= DLT_W'(target_z) - DLT_W'(pos[2]);
      dt <= step_time;
      for (int i = 0; i < 3; i++) frc[i] <= '0;
    end
    if (mg_done) begin
      case (state)
        ST_G_MAG: dq <= (mg_res < ONE) ? ONE : mg_res;
        ST_D_MAG: vq <= mg_res;
        ST_T_MAG: tgt_len <= mg_res;
        default:  lmag <= mg_res;
      endcase
    end
    if (md_done) begin
      case (state)
        ST_G_DIV1, ST_G_DIV2, ST_G_MASS, ST_D_V2, ST_D_DMAG, ST_T_K, ST_T_PG:
          tmp <= md_res;
        ST_D_AREA: dcfa <= md_res;
        ST_T_SAFE:
          kval <= (tgt_len < md_res) ? K_BRAKE : ((tgt_len < safety2) ? K_COAST : K_FULL);
        ST_T_MAG2: tmp <= (md_res > tmax) ? tmax : md_res;
        ST_G_FRC, ST_D_FRC: frc[idx] <= sat_add64(frc[idx], sat_neg64(md_res));
        // braking thrust points away from the target
        ST_T_FRC:
          frc[idx] <= sat_add64(frc[idx], (kval == K_BRAKE) ? sat_neg64(md_res) : md_res);
        ST_A_DIV, ST_A_SCL: acc[idx] <= md_res;
        default: ;
      endcase
    end
    if (state == ST_A_SAT) begin
      for (int i = 0; i < 3; i++) acc[i] <= 64'(sat_vel(acc[i]));
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      for (int i = 0; i < 3; i++) begin
        res_pos[i] <= pos[i];
        res_vel[i] <= vel[i];
        res_acc[i] <= acc[i][VEL_W-1:0];
      end
    end
  end

  assign pos_x = res_pos[0];
  assign pos_y = res_pos[1];
  assign pos_z = res_pos[2];
  assign vel_x = res_vel[0];
  assign vel_y = res_vel[1];
  assign vel_z = res_vel[2];
  assign acc_x = res_acc[0];
  assign acc_y = res_acc[1];
  assign acc_z = res_acc[2];

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import gbe_pkg::*;

  typedef struct packed {
    logic signed [POS_W-1:0] px, py, pz;
    logic signed [VEL_W-1:0] vx, vy, vz, ax, ay, az;
  } body_sample_t;

  typedef struct packed {
    logic rel;
    logic signed [POS_W-1:0] ox, oy, oz;
    logic [DT_W-1:0] dt;
  } aim_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [POS_W-1:0] target_x = '0, target_y = '0, target_z = '0;
  logic [DT_W-1:0] step_time = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [POS_W-1:0] pos_x, pos_y, pos_z;
  logic signed [VEL_W-1:0] vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic hold_go = 1'b0;

  guided_body_euler_step_top dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor copy of configuration and state
  logic [63:0] m_mass = 12800, m_thrust = 25600, m_drag = 6554, m_area = 32768;
  logic [63:0] m_vmax = 3276800, m_amax = 655360, m_gain = 62259, m_vac = 0;
  logic signed [63:0] b_pos [3];
  logic signed [63:0] b_vel [3];

  aim_item_t pending_aims[$];
  body_sample_t expected_states[$];
  int send_idle = 13, recv_idle = 66;
  int mismatches = 0, n_in = 0, n_out = 0, n_cfg = 0, idle_cyc = 0, hold_left = 0;

  function automatic logic [63:0] mul_div(logic [63:0] a, logic [63:0] b, logic [63:0] c);
    logic [127:0] p, q;
    if (c == 0) return '1;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:64] >= c) return '1;
    q = p / {64'd0, c};
    return q[63:0];
  endfunction

  function automatic logic signed [63:0] mul_div_s(logic signed [63:0] a, logic [63:0] b,
                                                   logic [63:0] c);
    logic neg;
    logic [63:0] m, q;
    neg = a[63];
    m = neg ? 64'd0 - a : a;
    q = mul_div(m, b, c);
    if (!neg) return q[63] ? S64_MAX : q;
    if (q[63]) return S64_MIN;
    return -$signed(q);
  endfunction

  function automatic logic signed [63:0] add_sat(logic signed [63:0] a, logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] neg_sat(logic signed [63:0] a);
    return (a == S64_MIN) ? S64_MAX : -a;
  endfunction

  function automatic logic signed [63:0] clip_to(logic signed [63:0] x, int n);
    logic signed [63:0] hi, lo;
    hi = (64'sd1 <<< (n - 1)) - 64'sd1;
    lo = -hi - 64'sd1;
    return x > hi ? hi : (x < lo ? lo : x);
  endfunction

  function automatic logic [63:0] root64(logic [63:0] n);
    logic [63:0] res, bv;
    res = 0;
    bv = 64'd1 << 62;
    while (bv > n) bv = bv >> 2;
    while (bv != 0) begin
      if (n >= res + bv) begin
        n = n - (res + bv);
        res = (res >> 1) + bv;
      end else begin
        res = res >> 1;
      end
      bv = bv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] vec_len(logic signed [63:0] a0, logic signed [63:0] a1,
                                          logic signed [63:0] a2);
    logic [63:0] u [3];
    logic [63:0] mx, sum;
    int s;
    u[0] = a0[63] ? 64'd0 - a0 : a0;
    u[1] = a1[63] ? 64'd0 - a1 : a1;
    u[2] = a2[63] ? 64'd0 - a2 : a2;
    mx = 0;
    sum = 0;
    s = 0;
    for (int i = 0; i < 3; i++) if (u[i] > mx) mx = u[i];
    while ((mx >> s) >= (64'd1 << 31)) s++;
    for (int i = 0; i < 3; i++) sum = sum + (u[i] >> s) * (u[i] >> s);
    return root64(sum) << s;
  endfunction

  // one euler step of the body, updates b_pos / b_vel
  function automatic body_sample_t advance_body(logic signed [POS_W-1:0] tx,
                                                logic signed [POS_W-1:0] ty,
                                                logic signed [POS_W-1:0] tz,
                                                logic [DT_W-1:0] dt);
    logic [63:0] one, mass, alim, dq, gq, fmag, vq, v2, dmag, tgt_len, safety, safety2;
    logic [63:0] tmax, tmag, amag, vmag;
    logic [3:0] k;
    logic signed [63:0] frc [3];
    logic signed [63:0] acc [3];
    logic signed [63:0] dlt [3];
    logic signed [63:0] c;
    body_sample_t r;
    one = ONE;
    mass = m_mass != 0 ? m_mass : 64'd1;
    alim = m_amax != 0 ? m_amax : 64'd1;
    dlt[0] = tx - b_pos[0];
    dlt[1] = ty - b_pos[1];
    dlt[2] = tz - b_pos[2];
    for (int i = 0; i < 3; i++) frc[i] = 0;
    if (m_vac == 0) begin
      dq = vec_len(b_pos[0], b_pos[1], b_pos[2]);
      if (dq < one) dq = one;
      gq = mul_div(mul_div(EARTH_GM, one, dq), one * one, dq);
      fmag = mul_div(gq, mass, 256);
      for (int i = 0; i < 3; i++)
        frc[i] = add_sat(frc[i], neg_sat(mul_div_s(b_pos[i], fmag, dq)));
    end
    vq = vec_len(b_vel[0], b_vel[1], b_vel[2]);
    if (vq * 1000 >= one) begin
      v2 = mul_div(vq, vq, one);
      dmag = mul_div(v2, m_drag * m_area, 64'd1 << 33);
      for (int i = 0; i < 3; i++)
        frc[i] = add_sat(frc[i], neg_sat(mul_div_s(b_vel[i], dmag, vq)));
    end
    tgt_len = vec_len(dlt[0], dlt[1], dlt[2]);
    if (!(tgt_len < one && tgt_len * 10 < one)) begin
      safety = mul_div(3 * vq, vq, 5 * alim);
      safety2 = safety > (64'hFFFF_FFFF_FFFF_FFFF >> 1) ? '1 : 2 * safety;
      k = tgt_len < safety ? K_BRAKE : (tgt_len < safety2 ? K_COAST : K_FULL);
      tmax = m_thrust << 8;
      tmag = mul_div(m_thrust * k * m_gain, one, 64'd167772160);
      if (tmag > tmax) tmag = tmax;
      for (int i = 0; i < 3; i++) begin
        c = mul_div_s(dlt[i], tmag, tgt_len);
        frc[i] = add_sat(frc[i], k == K_BRAKE ? neg_sat(c) : c);
      end
    end
    for (int i = 0; i < 3; i++) acc[i] = mul_div_s(frc[i], 256, mass);
    amag = vec_len(acc[0], acc[1], acc[2]);
    for (int i = 0; i < 3; i++) begin
      if (amag > alim) acc[i] = mul_div_s(acc[i], alim, amag);
      acc[i] = clip_to(acc[i], 32);
    end
    for (int i = 0; i < 3; i++)
      b_vel[i] = clip_to(add_sat(b_vel[i], mul_div_s(acc[i], dt, 65536)), 32);
    vmag = vec_len(b_vel[0], b_vel[1], b_vel[2]);
    if (vmag > m_vmax)
      for (int i = 0; i < 3; i++) b_vel[i] = mul_div_s(b_vel[i], m_vmax, vmag);
    for (int i = 0; i < 3; i++)
      b_pos[i] = clip_to(add_sat(b_pos[i], mul_div_s(b_vel[i], dt, 65536)), POS_W);
    r.px = b_pos[0][POS_W-1:0];
    r.py = b_pos[1][POS_W-1:0];
    r.pz = b_pos[2][POS_W-1:0];
    r.vx = b_vel[0][31:0];
    r.vy = b_vel[1][31:0];
    r.vz = b_vel[2][31:0];
    r.ax = acc[0][31:0];
    r.ay = acc[1][31:0];
    r.az = acc[2][31:0];
    return r;
  endfunction

  function automatic logic signed [POS_W-1:0] aim_axis(logic rel, logic signed [POS_W-1:0] off,
                                                       logic signed [63:0] p);
    logic signed [63:0] t;
    if (!rel) return off;
    t = clip_to(p + off, POS_W);
    return t[POS_W-1:0];
  endfunction

  // driver
  always @(posedge clk) begin
    aim_item_t it;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_states.push_back(advance_body(target_x, target_y, target_z, step_time));
        n_in++;
      end
      if (!(in_valid && !in_ready)) begin
        if (pending_aims.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          it = pending_aims.pop_front();
          target_x <= aim_axis(it.rel, it.ox, b_pos[0]);
          target_y <= aim_axis(it.rel, it.oy, b_pos[1]);
          target_z <= aim_axis(it.rel, it.oz, b_pos[2]);
          step_time <= it.dt;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    body_sample_t e, a;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        a = {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z};
        n_out++;
        if (expected_states.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transfer: %p", a);
        end else begin
          e = expected_states.pop_front();
          if (e !== a) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch\n  exp %p\n  got %p", n_out, e, a);
          end
        end
      end
      if (hold_go) hold_left = 8000;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  // watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cyc <= 0;
    else idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= 40000) begin
      $display("guided_body_euler_step_top verification failed");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [30:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    case (r)
      REG_BODY_MASS:      m_mass = v[15:0];
      REG_THRUST_LIMIT:   m_thrust = v[19:0];
      REG_DRAG_COEFF:     m_drag = v[15:0];
      REG_FRONTAL_AREA:   m_area = v[23:0];
      REG_SPEED_LIMIT:    m_vmax = v[30:0];
      REG_ACCEL_LIMIT:    m_amax = v[30:0];
      REG_PRECISION_GAIN: m_gain = v[16:0];
      REG_IN_VACUUM:      m_vac = v[0];
      default: ;
    endcase
    n_cfg++;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [30:0] v [8]);
    for (int i = 0; i < 8; i++) write_reg(cfg_reg_t'(i), v[i]);
  endtask

  task automatic random_cfg();
    logic [30:0] v [8];
    for (int i = 0; i < 8; i++) v[i] = 31'($urandom);
    // keep the body controllable most of the time
    if ($urandom_range(0, 3) != 0) begin
      v[0] = 31'($urandom_range(256, 65535));
      v[4] = 31'($urandom_range(65536, 1 << 24));
      v[5] = 31'($urandom_range(1000, 1 << 22));
    end
    write_all(v);
  endtask

  task automatic push_aim(logic rel, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                          logic signed [POS_W-1:0] z, logic [DT_W-1:0] dt);
    aim_item_t it;
    it.rel = rel;
    it.ox = x;
    it.oy = y;
    it.oz = z;
    it.dt = dt;
    pending_aims.push_back(it);
  endtask

  function automatic logic signed [POS_W-1:0] rnd_span(int bits);
    logic [63:0] r;
    logic signed [63:0] t;
    r = {$urandom, $urandom};
    t = clip_to($signed(r) >>> (64 - bits), POS_W);
    return t[POS_W-1:0];
  endfunction

  task automatic push_random(int n);
    int sel;
    logic [DT_W-1:0] dt;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      dt = $urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? '1 : '0) : DT_W'($urandom);
      if (sel < 45) push_aim(1'b1, rnd_span(22), rnd_span(22), rnd_span(22), dt);
      else if (sel < 65) push_aim(1'b0, rnd_span(28), rnd_span(28), rnd_span(28), dt);
      else if (sel < 78) push_aim(1'b1, rnd_span(12), rnd_span(12), rnd_span(12), dt);
      else if (sel < 90) push_aim(1'b0, rnd_span(40), rnd_span(40), rnd_span(40), dt);
      else push_aim(1'b1, '0, '0, '0, dt);
    end
  endtask

  task automatic drain();
    while (pending_aims.size() > 0 || in_valid || expected_states.size() > 0)
      @(posedge clk);
    repeat (3200) @(posedge clk);
  endtask

  initial begin
    logic [30:0] v [8];
    logic signed [POS_W-1:0] pmax, pmin;
    pmax = POS_MAX[POS_W-1:0];
    pmin = POS_MIN[POS_W-1:0];
    for (int i = 0; i < 3; i++) begin
      b_pos[i] = 0;
      b_vel[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: reset settings
    push_aim(1'b0, '0, '0, '0, '0);
    push_aim(1'b0, 40'sd5000, '0, '0, '1);
    push_aim(1'b0, pmax, pmax, pmax, '1);
    push_aim(1'b0, pmin, pmin, pmin, '1);
    push_aim(1'b0, pmax, pmin, '0, 16'd1);
    push_aim(1'b1, '0, '0, '0, '1);
    for (int i = 0; i < 6; i++) push_aim(1'b0, 40'sd1 <<< 22, 40'sd1 <<< 22, -40'sd3, '1);
    // near target at speed so the braking and coasting bands come up
    for (int i = 0; i < 6; i++) push_aim(1'b1, 40'sd20000 * i, -40'sd7000, 40'sd3000, '1);
    push_aim(1'b1, 40'sd6000, '0, '0, '0);
    push_aim(1'b0, -40'sd1, 40'sd1, '0, 16'd32768);
    push_random(230);
    drain();

    // random settings, with the long output hold-off to fill the block
    random_cfg();
    push_random(40);
    @(posedge clk);
    hold_go <= 1'b1;
    @(posedge clk);
    hold_go <= 1'b0;
    push_random(200);
    drain();

    send_idle = 66;
    recv_idle = 13;
    // all registers at the low end, vacuum
    v = '{default: 31'd0};
    v[7] = 31'd1;
    write_all(v);
    push_random(100);
    drain();

    // all registers at the top of their fields, vacuum off
    v = '{default: 31'h7FFF_FFFF};
    v[7] = 31'd0;
    write_all(v);
    push_random(230);
    drain();

    random_cfg();
    push_random(230);
    drain();

    send_idle = 0;
    recv_idle = 0;
    // tiny acceleration limit makes the stopping distance large
    v[0] = 31'd12800; v[1] = 31'd1048575; v[2] = 31'd6554; v[3] = 31'd32768;
    v[4] = 31'd6553600; v[5] = 31'd2000; v[6] = 31'd131071; v[7] = 31'd1;
    write_all(v);
    push_random(300);
    drain();

    random_cfg();
    push_random(300);
    drain();

    $display("covered %0d steps, %0d results and %0d register writes", n_in, n_out, n_cfg);
    $display("over seven settings including both extremes and a long output stall");
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("guided_body_euler_step_top verification clean");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_states.size());
      $display("guided_body_euler_step_top verification failed");
    end
    $finish;
  end

endmodule
